@@ src/text_console_cursor_engine_assert.svh @@
// Assertion shorthands for the console cursor engine checker.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH

// Checked at every clock edge outside reset.
`define TCCE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tcce assertion failed");

// Checked at every clock edge, reset included.
`define TCCE_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tcce assertion failed");

`endif

@@ src/tcce_pkg.sv @@
package tcce_pkg;

    // default geometry limits and tab width
    localparam int DEF_MAX_COLUMNS = 256;
    localparam int DEF_MAX_ROWS    = 128;
    localparam int DEF_TAB_SPACES  = 4;
    localparam int DEF_QUEUE_DEPTH = 4;

    // results per item
    localparam int RESULT_LIMIT = 8;
    localparam int CNT_W        = 4;
    // repeat count of one op (tab width up to 15)
    localparam int REPS_W       = 4;

    // reset values of the config registers
    localparam logic [8:0]  COLUMNS_RESET = 9'd80;
    localparam logic [7:0]  ROWS_RESET    = 8'd25;
    localparam logic [23:0] FORE_RESET    = 24'hFFFFFF;
    localparam logic [23:0] BACK_RESET    = 24'h000000;

    // config register indexes
    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;
    localparam logic [1:0] CFG_FORE    = 2'd2;
    localparam logic [1:0] CFG_BACK    = 2'd3;

    // character codes
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    typedef enum logic [1:0] {
        CMD_DRAW         = 2'd0,
        CMD_CLEAR_CELL   = 2'd1,
        CMD_SCROLL       = 2'd2,
        CMD_CLEAR_SCREEN = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        OP_PRINT     = 3'd0,
        OP_NEWLINE   = 3'd1,
        OP_BACKSPACE = 3'd2,
        OP_RETURN    = 3'd3,
        OP_FORMFEED  = 3'd4,
        OP_SETCUR    = 3'd5
    } t_op;

    typedef enum logic {
        BK_DRAW   = 1'b0,
        BK_SCROLL = 1'b1
    } t_back_state;

    // one classified op in the queue
    typedef struct packed {
        t_op               op;
        logic [REPS_W-1:0] reps;
        logic [6:0]        glyph;
        logic [7:0]        col;
        logic [6:0]        row;
    } t_op_entry;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_status;

    typedef struct packed {
        t_cmd        command;
        logic [7:0]  col;
        logic [6:0]  row;
        logic [6:0]  glyph;
        logic [23:0] colour;
        logic        last;
    } t_result;

endpackage

@@ src/tcce_front.sv @@
module tcce_front
    import tcce_pkg::*;
#(
    parameter int TAB_SPACES = DEF_TAB_SPACES
) (
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_kind,
    input  logic [7:0] i_char_code,
    input  logic [7:0] i_new_column,
    input  logic [6:0] i_new_row,
    input  t_q_status  i_q_status,
    output logic       o_push,
    output t_op_entry  o_entry
);

    logic keep;

    // decode one beat into a queue op; codes with no effect are dropped here
    always_comb begin
        keep          = 1'b1;
        o_entry.op    = OP_PRINT;
        o_entry.reps  = REPS_W'(1);
        o_entry.glyph = i_char_code[6:0];
        o_entry.col   = i_new_column;
        o_entry.row   = i_new_row;
        if (i_kind) begin
            o_entry.op = OP_SETCUR;
        end else begin
            unique case (i_char_code) inside
                CH_LF, CH_VT: begin
                    o_entry.op = OP_NEWLINE;
                end
                CH_BS: begin
                    o_entry.op = OP_BACKSPACE;
                end
                CH_CR: begin
                    o_entry.op = OP_RETURN;
                end
                CH_FF: begin
                    o_entry.op = OP_FORMFEED;
                end
                CH_TAB: begin
                    o_entry.op    = OP_PRINT;
                    o_entry.reps  = REPS_W'(TAB_SPACES);
                    o_entry.glyph = CH_SPACE[6:0];
                end
                [CH_SPACE:CH_TILDE]: begin
                    o_entry.op = OP_PRINT;
                end
                default: begin
                    keep = 1'b0;
                end
            endcase
        end
    end

    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full && keep;

endmodule

@@ src/tcce_queue.sv @@
module tcce_queue
    import tcce_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_op_entry i_entry,
    input  logic      i_pop,
    output t_op_entry o_head,
    output t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    t_op_entry         r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_status.not_empty = (r_count != '0);
    assign o_status.full      = (r_count == CNT_QW'(DEPTH));
    assign do_push            = i_push && !o_status.full;
    assign do_pop             = i_pop && o_status.not_empty;
    assign o_head             = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ src/tcce_back.sv @@
module tcce_back
    import tcce_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_op_entry   i_head,
    input  t_q_status   i_q_status,
    output logic        o_pop,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_result     o_result
);

    localparam logic [8:0] COL_MAX = 9'(MAX_COLUMNS);
    localparam logic [7:0] ROW_MAX = 8'(MAX_ROWS);

    t_back_state       r_state;
    t_back_state       n_state;
    logic [7:0]        r_col;
    logic [7:0]        n_col;
    logic [6:0]        r_row;
    logic [6:0]        n_row;
    logic [REPS_W-1:0] r_step;
    logic [REPS_W-1:0] n_step;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [8:0]        r_columns;
    logic [7:0]        r_rows;
    logic [23:0]       r_fore;
    logic [23:0]       r_back;
    logic              r_valid;
    t_result           r_result;
    t_result           n_result;

    logic       can_emit;
    logic       emit_ok;
    logic       last_space;
    logic [8:0] col_inc;
    logic [7:0] row_inc;
    logic       wrap;
    logic       row_over;
    logic       scroll_due;
    logic [7:0] col_lim;
    logic [6:0] row_lim;
    logic       fire;
    logic       emit;
    logic       done;
    logic       cfg_wr;
    logic [8:0] cfg_cols;
    logic [7:0] cfg_rows;
    logic [7:0] cfg_col_lim;
    logic [6:0] cfg_row_lim;

    assign can_emit   = !r_valid || !i_stall;
    assign emit_ok    = (r_cnt < CNT_W'(RESULT_LIMIT));
    assign last_space = (r_step == i_head.reps - 1'b1);
    assign col_inc    = {1'b0, r_col} + 9'd1;
    assign row_inc    = {1'b0, r_row} + 8'd1;
    assign wrap       = (col_inc >= r_columns);
    assign row_over   = (row_inc >= r_rows);
    assign scroll_due = wrap && row_over;
    assign col_lim    = 8'(r_columns - 9'd1);
    assign row_lim    = 7'(r_rows - 8'd1);

    // step control: when the head op advances, whether it emits, when it retires
    always_comb begin
        fire = 1'b0;
        emit = 1'b0;
        done = 1'b0;
        unique case (i_head.op)
            OP_SETCUR, OP_RETURN: begin
                fire = 1'b1;
                done = 1'b1;
            end
            OP_FORMFEED, OP_BACKSPACE: begin
                fire = can_emit;
                emit = 1'b1;
                done = 1'b1;
            end
            OP_NEWLINE: begin
                fire = !row_over || can_emit;
                emit = row_over;
                done = 1'b1;
            end
            OP_PRINT: begin
                fire = !emit_ok || can_emit;
                emit = emit_ok;
                done = (r_state == BK_SCROLL) ? last_space : (last_space && !scroll_due);
            end
            default: begin
                fire = 1'b1;
                done = 1'b1;
            end
        endcase
        fire = fire && i_q_status.not_empty;
        emit = emit && fire;
        done = done && fire;
    end

    // next state
    always_comb begin
        n_state = r_state;
        if (fire && i_head.op == OP_PRINT) begin
            unique case (r_state)
                BK_DRAW: begin
                    if (scroll_due && !last_space) begin
                        n_state = BK_SCROLL;
                    end else if (scroll_due) begin
                        n_state = BK_SCROLL;
                    end
                end
                BK_SCROLL: begin
                    n_state = BK_DRAW;
                end
                default: begin
                    n_state = BK_DRAW;
                end
            endcase
        end
    end

    // cursor update and result payload for the head op
    always_comb begin
        n_col             = r_col;
        n_row             = r_row;
        n_step            = r_step;
        n_result.command  = CMD_DRAW;
        n_result.col      = '0;
        n_result.row      = '0;
        n_result.glyph    = '0;
        n_result.colour   = r_back;
        n_result.last     = 1'b1;
        unique case (i_head.op)
            OP_SETCUR: begin
                n_col = (i_head.col > col_lim) ? col_lim : i_head.col;
                n_row = (i_head.row > row_lim) ? row_lim : i_head.row;
            end
            OP_RETURN: begin
                n_col = '0;
            end
            OP_FORMFEED: begin
                n_result.command = CMD_CLEAR_SCREEN;
                n_col            = '0;
                n_row            = '0;
            end
            OP_NEWLINE: begin
                n_col            = '0;
                n_result.command = CMD_SCROLL;
                n_row            = row_over ? row_lim : row_inc[6:0];
            end
            OP_BACKSPACE: begin
                if (r_col == '0) begin
                    if (r_row != '0) begin
                        n_row = r_row - 1'b1;
                        n_col = col_lim;
                    end
                end else begin
                    n_col = r_col - 1'b1;
                end
                n_result.command = CMD_CLEAR_CELL;
                n_result.col     = n_col;
                n_result.row     = n_row;
            end
            OP_PRINT: begin
                if (r_state == BK_DRAW) begin
                    n_result.command = CMD_DRAW;
                    n_result.col     = r_col;
                    n_result.row     = r_row;
                    n_result.glyph   = i_head.glyph;
                    n_result.colour  = r_fore;
                    n_result.last    = (r_cnt == CNT_W'(RESULT_LIMIT - 1)) ||
                                       (last_space && !scroll_due);
                    if (wrap) begin
                        n_col = '0;
                        if (!row_over) begin
                            n_row = row_inc[6:0];
                        end
                    end else begin
                        n_col = col_inc[7:0];
                    end
                    if (!scroll_due) begin
                        n_step = r_step + 1'b1;
                    end
                end else begin
                    n_result.command = CMD_SCROLL;
                    n_result.last    = (r_cnt == CNT_W'(RESULT_LIMIT - 1)) || last_space;
                    n_row            = row_lim;
                    n_step           = r_step + 1'b1;
                end
            end
            default: begin
                n_col = r_col;
            end
        endcase
        if (done) begin
            n_step = '0;
        end
        n_cnt = done ? '0 : (emit ? r_cnt + 1'b1 : r_cnt);
    end

    // config write saturation and cursor clamp
    always_comb begin
        cfg_cols = i_cfg_data[8:0];
        cfg_rows = i_cfg_data[7:0];
        if (cfg_cols == '0) begin
            cfg_cols = 9'd1;
        end else if (cfg_cols > COL_MAX) begin
            cfg_cols = COL_MAX;
        end
        if (cfg_rows == '0) begin
            cfg_rows = 8'd1;
        end else if (cfg_rows > ROW_MAX) begin
            cfg_rows = ROW_MAX;
        end
        cfg_col_lim = 8'(cfg_cols - 9'd1);
        cfg_row_lim = 7'(cfg_rows - 8'd1);
    end

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_DRAW;
            r_col     <= '0;
            r_row     <= '0;
            r_step    <= '0;
            r_cnt     <= '0;
            r_columns <= COLUMNS_RESET;
            r_rows    <= ROWS_RESET;
            r_fore    <= FORE_RESET;
            r_back    <= BACK_RESET;
            r_valid   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (i_cfg_index)
                    CFG_COLUMNS: begin
                        r_columns <= cfg_cols;
                        if (r_col > cfg_col_lim) begin
                            r_col <= cfg_col_lim;
                        end
                    end
                    CFG_ROWS: begin
                        r_rows <= cfg_rows;
                        if (r_row > cfg_row_lim) begin
                            r_row <= cfg_row_lim;
                        end
                    end
                    CFG_FORE: begin
                        r_fore <= i_cfg_data;
                    end
                    CFG_BACK: begin
                        r_back <= i_cfg_data;
                    end
                    default: begin
                        r_fore <= r_fore;
                    end
                endcase
            end else if (fire) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (fire) begin
                r_state <= n_state;
                r_step  <= n_step;
                r_cnt   <= n_cnt;
            end
            if (emit) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_result <= n_result;
        end
    end

    assign o_pop    = done;
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ src/text_console_cursor_engine.sv @@
// Character-cell console cursor engine.
// Input channel (i_valid / o_stall): one beat is a character to print
// (i_kind = 0) or a set-cursor request (i_kind = 1). A beat is taken when
// i_valid is high and o_stall is low; o_stall rises only when the op queue
// between decode and execute is full.
// Output channel (o_valid / i_stall): one drawing command per beat, o_last
// marks the final command of an input. A stalled command holds steady.
// Config channel (i_cfg_valid / o_cfg_ready): o_cfg_ready is always high;
// index 0 columns, 1 rows, 2 fore colour, 3 back colour. Write only while idle.
// An accepted beat passes through the op queue, and its command is then
// registered in the output register. The executor retires one step per
// cycle while the op queue holds an op and no output stall holds it; a
// print that wraps past the bottom row takes a draw step and a scroll step.
// Throughput is one command per cycle while the receiver keeps i_stall low.
// Reset (i_rst_n low, synchronous): cursor to 0,0, geometry 80 x 25,
// fore white, back black, queue and output register emptied.
module text_console_cursor_engine
    import tcce_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int TAB_SPACES  = DEF_TAB_SPACES,
    parameter int Q_DEPTH     = DEF_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_new_column,
    input  logic [6:0]  i_new_row,
    // config writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    // command output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_command,
    output logic [7:0]  o_cell_column,
    output logic [6:0]  o_cell_row,
    output logic [6:0]  o_glyph,
    output logic [23:0] o_colour,
    output logic        o_last
);

    t_q_status q_status;
    t_op_entry push_entry;
    t_op_entry head;
    logic      push;
    logic      pop;
    t_result   result;

    // decode: classify the beat, drop codes that do nothing
    tcce_front #(
        .TAB_SPACES (TAB_SPACES)
    ) u_front (
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_char_code  (i_char_code),
        .i_new_column (i_new_column),
        .i_new_row    (i_new_row),
        .i_q_status   (q_status),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    // short op queue decouples decode from execute
    tcce_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    // execute: cursor, geometry and colours, one step per cycle unless stalled
    tcce_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (result)
    );

    assign o_command     = result.command;
    assign o_cell_column = result.col;
    assign o_cell_row    = result.row;
    assign o_glyph       = result.glyph;
    assign o_colour      = result.colour;
    assign o_last        = result.last;

endmodule

@@ src/tcce_checker.sv @@
`include "text_console_cursor_engine_assert.svh"

module tcce_checker
    import tcce_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_command,
    input logic [7:0]  o_cell_column,
    input logic [6:0]  o_cell_row,
    input logic [6:0]  o_glyph,
    input logic [23:0] o_colour,
    input logic        o_last
);

    // a held command beat keeps its payload
    `TCCE_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_command) && $stable(o_cell_column) && $stable(o_cell_row) && $stable(o_glyph) && $stable(o_colour) && $stable(o_last))

    // reset empties the output register
    `TCCE_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid)

    // only draw commands carry a glyph
    `TCCE_ASSERT(a_glyph_draw_only, i_clk, i_rst_n, o_valid && o_command != CMD_DRAW |-> o_glyph == 7'd0)

    // clear screen and clear cell are always the single command of their input
    `TCCE_ASSERT(a_clear_last, i_clk, i_rst_n, o_valid && (o_command == CMD_CLEAR_SCREEN || o_command == CMD_CLEAR_CELL) |-> o_last)

endmodule

bind text_console_cursor_engine tcce_checker u_tcce_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_command     (o_command),
    .o_cell_column (o_cell_column),
    .o_cell_row    (o_cell_row),
    .o_glyph       (o_glyph),
    .o_colour      (o_colour),
    .o_last        (o_last)
);
